@@ rtl/core/damped_spring_force_assert.svh @@
// assertion macros shared by the spring force rtl
// expects clk and rst in the scope of each use
`ifndef DAMPED_SPRING_FORCE_ASSERT_SVH
`define DAMPED_SPRING_FORCE_ASSERT_SVH

// checked outside reset
`define DSF_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// checked on every edge, reset included
`define DSF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

@@ rtl/core/dsf_pkg.sv @@
// shared widths, register codes and types for the spring force pipeline
// no dependencies
package dsf_pkg;

  localparam int LEN_W = 33;          // spring length, raw fixed point
  localparam int RAD_W = 2 * LEN_W;   // sum of squared differences
  localparam int SUM_W = 66;          // exact force sums before clipping

  localparam logic [1:0] REG_STIFFNESS = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_GRAVITY_Y = 2'd2;

  typedef struct packed {
    logic [30:0]        stiffness;
    logic [30:0]        damping;
    logic signed [31:0] gravity_y;
  } cfg_t;

  // clip an exact sum to 32 bits
  function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
    logic [31:0] r;
    if (!v[SUM_W-1] && (|v[SUM_W-2:31])) begin
      r = 32'h7fff_ffff;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic clipped(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? !(&v[SUM_W-2:31]) : (|v[SUM_W-2:31]);
  endfunction

endpackage

@@ rtl/core/dsf_apb.sv @@
// configuration registers behind an apb-style port
// depends on dsf_pkg
module dsf_apb #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output dsf_pkg::cfg_t cfg
);
  import dsf_pkg::*;

  localparam logic [30:0] STIFF_RST = 31'(100 << FRAC_BITS);
  localparam logic [30:0] DAMP_RST  = 31'(1 << (FRAC_BITS - 1));
  localparam int          GRAV_MAG  = ((98 << FRAC_BITS) + 5000) / 10000;
  localparam logic [31:0] GRAV_RST  = 32'(-GRAV_MAG);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stiffness <= STIFF_RST;
      cfg.damping   <= DAMP_RST;
      cfg.gravity_y <= GRAV_RST;
    end else if (wr) begin
      case (idx)
        REG_STIFFNESS: cfg.stiffness <= pwdata[30:0];
        REG_DAMPING:   cfg.damping   <= pwdata[30:0];
        REG_GRAVITY_Y: cfg.gravity_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STIFFNESS: prdata = {1'b0, cfg.stiffness};
      REG_DAMPING:   prdata = {1'b0, cfg.damping};
      REG_GRAVITY_Y: prdata = cfg.gravity_y;
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/dsf_sqrt.sv @@
// pipelined integer square root, one root bit per stage, with a sideband
// depends on dsf_pkg and damped_spring_force_assert.svh
`include "damped_spring_force_assert.svh"
module dsf_sqrt #(
  parameter int SW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_vld,
  input  logic [dsf_pkg::RAD_W-1:0]  rad,
  input  logic [SW-1:0]              side_in,
  output logic                       out_vld,
  output logic [dsf_pkg::LEN_W-1:0]  root,
  output logic [SW-1:0]              side_out
);
  import dsf_pkg::*;

  localparam int NS    = LEN_W;
  localparam int REM_W = LEN_W + 4;

  logic             vld_q  [NS];
  logic [RAD_W-1:0] rad_q  [NS];
  logic [REM_W-1:0] rem_q  [NS];
  logic [LEN_W-1:0] root_q [NS];
  logic [SW-1:0]    side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic             vs;
    logic [RAD_W-1:0] rs;
    logic [REM_W-1:0] ms;
    logic [LEN_W-1:0] ts;
    logic [SW-1:0]    ss;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vs = in_vld;
      assign rs = rad;
      assign ms = '0;
      assign ts = '0;
      assign ss = side_in;
    end else begin : g_next
      assign vs = vld_q[k-1];
      assign rs = rad_q[k-1];
      assign ms = rem_q[k-1];
      assign ts = root_q[k-1];
      assign ss = side_q[k-1];
    end

    // bring down the next radicand pair, try (root << 2) | 1
    assign sh    = {ms[REM_W-3:0], rs[2*(NS-1-k)+1 -: 2]};
    assign trial = {2'b00, ts, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (ce) begin
        vld_q[k] <= vs;
      end
      if (ce) begin
        rad_q[k]  <= rs;
        rem_q[k]  <= ge ? sh - trial : sh;
        root_q[k] <= {ts[LEN_W-2:0], ge};
        side_q[k] <= ss;
      end
    end
  end

  assign out_vld  = vld_q[NS-1];
  assign root     = root_q[NS-1];
  assign side_out = side_q[NS-1];

  `DSF_ASSERT(a_sqrt_rem_bound, (vld_q[NS-1] |-> (rem_q[NS-1] <= {3'b000, root_q[NS-1], 1'b0})), "sqrt remainder above twice the root")

endmodule

@@ rtl/core/dsf_div.sv @@
// three-lane pipelined restoring divider by a shared divisor, one quotient bit per stage
// depends on dsf_pkg and damped_spring_force_assert.svh
`include "damped_spring_force_assert.svh"
module dsf_div #(
  parameter int QW = 48,
  parameter int SW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_vld,
  input  logic [2:0][31:0]           num_hi,
  input  logic [2:0][QW-1:0]         num_lo,
  input  logic [dsf_pkg::LEN_W-1:0]  den,
  input  logic [SW-1:0]              side_in,
  output logic                       out_vld,
  output logic [2:0][QW-1:0]         quot,
  output logic [SW-1:0]              side_out
);
  import dsf_pkg::*;

  logic                   vld_q  [QW];
  logic [2:0][LEN_W-1:0]  rem_q  [QW];
  logic [2:0][QW-1:0]     lo_q   [QW];
  logic [2:0][QW-1:0]     q_q    [QW];
  logic [LEN_W-1:0]       den_q  [QW];
  logic [SW-1:0]          side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic                  vs;
    logic [2:0][LEN_W-1:0] ms;
    logic [2:0][QW-1:0]    ls;
    logic [2:0][QW-1:0]    qs;
    logic [LEN_W-1:0]      ds;
    logic [SW-1:0]         ss;
    logic [2:0][LEN_W-1:0] mn;
    logic [2:0][QW-1:0]    qn;

    if (k == 0) begin : g_first
      // the high word is below den whenever the quotient fits QW bits
      assign vs = in_vld;
      assign ms = {{1'b0, num_hi[2]}, {1'b0, num_hi[1]}, {1'b0, num_hi[0]}};
      assign ls = num_lo;
      assign qs = '0;
      assign ds = den;
      assign ss = side_in;
    end else begin : g_next
      assign vs = vld_q[k-1];
      assign ms = rem_q[k-1];
      assign ls = lo_q[k-1];
      assign qs = q_q[k-1];
      assign ds = den_q[k-1];
      assign ss = side_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [LEN_W:0] rs;
        logic           ge;
        rs    = {ms[l], ls[l][QW-1-k]};
        ge    = (rs >= {1'b0, ds});
        mn[l] = ge ? LEN_W'(rs - {1'b0, ds}) : rs[LEN_W-1:0];
        qn[l] = {qs[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (ce) begin
        vld_q[k] <= vs;
      end
      if (ce) begin
        rem_q[k]  <= mn;
        lo_q[k]   <= ls;
        q_q[k]    <= qn;
        den_q[k]  <= ds;
        side_q[k] <= ss;
      end
    end
  end

  assign out_vld  = vld_q[QW-1];
  assign quot     = q_q[QW-1];
  assign side_out = side_q[QW-1];

  `DSF_ASSERT(a_div_rem_bound, ((vld_q[QW-1] && (den_q[QW-1] != '0)) |-> ((rem_q[QW-1][0] < den_q[QW-1]) && (rem_q[QW-1][1] < den_q[QW-1]) && (rem_q[QW-1][2] < den_q[QW-1]))), "divider remainder not below divisor")

endmodule

@@ rtl/core/damped_spring_force.sv @@
// Damped spring force pipeline: one spring per transfer, forces on both ends.
// Accepts a new spring every cycle while the output is taken; values are Q16.16
// at the default FRAC_BITS. The pipeline includes the 33-stage square root and
// the (64 - FRAC_BITS)-stage divider that forms the spring term. A stall on the
// output holds the whole pipeline. Coincident endpoints drop the spring term
// and raise zero_length; any clipped force component raises saturated.
// Depends on dsf_pkg, dsf_apb, dsf_sqrt, dsf_div and damped_spring_force_assert.svh.
`include "damped_spring_force_assert.svh"
module damped_spring_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // apb configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // spring input
  input  logic          s_tvalid,
  output logic          s_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
  // rel_vel_x, rel_vel_y, rel_vel_z, rest_length, zero pad
  input  logic [319:0]  s_tdata,
  // force output
  output logic          m_tvalid,
  input  logic          m_tready,
  // force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z
  output logic [191:0]  m_tdata,
  // zero_length, saturated
  output logic [1:0]    m_tuser
);
  import dsf_pkg::*;

  localparam int QW = 64 - FRAC_BITS;

  typedef struct packed {
    logic [2:0][31:0] md;
    logic [2:0]       nd;
    logic [2:0][63:0] dmp;
    logic [30:0]      rest;
  } sq_side_t;

  typedef struct packed {
    logic             zero;
    logic [2:0]       nh;
    logic [2:0][63:0] dmp;
  } dv_side_t;

  cfg_t cfg;
  logic ce;

  dsf_apb #(.FRAC_BITS(FRAC_BITS)) u_apb (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // stage 1: input register
  logic              s1_vld;
  logic [2:0][31:0]  s1_a, s1_b, s1_v;
  logic [30:0]       s1_rest;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (ce) begin
      s1_vld <= s_tvalid;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= s_tdata[32*i +: 32];
        s1_b[i] <= s_tdata[96 + 32*i +: 32];
        s1_v[i] <= s_tdata[192 + 32*i +: 32];
      end
      s1_rest <= s_tdata[318:288];
    end
  end

  // stage 2: differences, magnitudes, damping product
  logic              s2_vld;
  logic [2:0][31:0]  s2_md;
  logic [2:0]        s2_nd, s2_nv;
  logic [2:0][62:0]  s2_dm;
  logic [30:0]       s2_rest;
  logic [2:0][32:0]  d_c;
  logic [2:0][31:0]  vm_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]  = {s1_a[i][31], s1_a[i]} - {s1_b[i][31], s1_b[i]};
      vm_c[i] = s1_v[i][31] ? 32'(-s1_v[i]) : s1_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (ce) begin
      s2_vld <= s1_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s2_md[i] <= d_c[i][32] ? 32'(-d_c[i]) : d_c[i][31:0];
        s2_nd[i] <= d_c[i][32];
        s2_nv[i] <= s1_v[i][31];
        s2_dm[i] <= cfg.damping * vm_c[i];
      end
      s2_rest <= s1_rest;
    end
  end

  // stage 3: squares, signed damping term
  logic              s3_vld;
  logic [2:0][63:0]  s3_sq;
  logic [2:0][31:0]  s3_md;
  logic [2:0]        s3_nd;
  logic [2:0][63:0]  s3_dmp;
  logic [30:0]       s3_rest;
  logic [2:0][63:0]  dms_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dms_c[i] = 64'(s2_dm[i] >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (ce) begin
      s3_vld <= s2_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s3_sq[i]  <= s2_md[i] * s2_md[i];
        s3_dmp[i] <= s2_nv[i] ? -dms_c[i] : dms_c[i];
      end
      s3_md   <= s2_md;
      s3_nd   <= s2_nd;
      s3_rest <= s2_rest;
    end
  end

  // stage 4: squared length
  logic              s4_vld;
  logic [RAD_W-1:0]  s4_rad;
  sq_side_t          s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (ce) begin
      s4_vld <= s3_vld;
    end
    if (ce) begin
      s4_rad       <= RAD_W'(s3_sq[0]) + RAD_W'(s3_sq[1]) + RAD_W'(s3_sq[2]);
      s4_side.md   <= s3_md;
      s4_side.nd   <= s3_nd;
      s4_side.dmp  <= s3_dmp;
      s4_side.rest <= s3_rest;
    end
  end

  logic              sq_vld;
  logic [LEN_W-1:0]  sq_len;
  sq_side_t          sq_side;

  dsf_sqrt #(.SW($bits(sq_side_t))) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(s4_vld), .rad(s4_rad), .side_in(s4_side),
    .out_vld(sq_vld), .root(sq_len), .side_out(sq_side)
  );

  // stage 5: stretch against rest length
  logic              s5_vld, s5_zero, s5_ndiff;
  logic [LEN_W-1:0]  s5_len, s5_mdiff;
  logic [2:0][31:0]  s5_md;
  logic [2:0]        s5_nd;
  logic [2:0][63:0]  s5_dmp;
  logic [LEN_W+1:0]  diff_c;

  assign diff_c = {2'b00, sq_len} - {4'b0000, sq_side.rest};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (ce) begin
      s5_vld <= sq_vld;
    end
    if (ce) begin
      s5_len   <= sq_len;
      s5_zero  <= (sq_len == '0);
      s5_ndiff <= diff_c[LEN_W+1];
      s5_mdiff <= diff_c[LEN_W+1] ? LEN_W'(-diff_c) : diff_c[LEN_W-1:0];
      s5_md    <= sq_side.md;
      s5_nd    <= sq_side.nd;
      s5_dmp   <= sq_side.dmp;
    end
  end

  // stage 6: stiffness times stretch
  logic              s6_vld, s6_zero;
  logic [63:0]       s6_p;
  logic [LEN_W-1:0]  s6_len;
  logic [2:0][31:0]  s6_md;
  logic [2:0]        s6_nh;
  logic [2:0][63:0]  s6_dmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (ce) begin
      s6_vld <= s5_vld;
    end
    if (ce) begin
      s6_p    <= cfg.stiffness * s5_mdiff;
      s6_len  <= s5_len;
      s6_zero <= s5_zero;
      s6_md   <= s5_md;
      s6_nh   <= s5_nd ^ {3{s5_ndiff}};
      s6_dmp  <= s5_dmp;
    end
  end

  // stage 7: partial products of p times |d|
  logic              s7_vld, s7_zero;
  logic [2:0][63:0]  s7_pl, s7_ph;
  logic [LEN_W-1:0]  s7_len;
  logic [2:0]        s7_nh;
  logic [2:0][63:0]  s7_dmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (ce) begin
      s7_vld <= s6_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s7_pl[i] <= s6_p[31:0] * s6_md[i];
        s7_ph[i] <= s6_p[63:32] * s6_md[i];
      end
      s7_len  <= s6_len;
      s7_zero <= s6_zero;
      s7_nh   <= s6_nh;
      s7_dmp  <= s6_dmp;
    end
  end

  // stage 8: full 96-bit product
  logic              s8_vld;
  logic [2:0][95:0]  s8_pm;
  logic [LEN_W-1:0]  s8_len;
  dv_side_t          s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (ce) begin
      s8_vld <= s7_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s8_pm[i] <= {32'h0, s7_pl[i]} + {s7_ph[i], 32'h0};
      end
      s8_len       <= s7_len;
      s8_side.zero <= s7_zero;
      s8_side.nh   <= s7_nh;
      s8_side.dmp  <= s7_dmp;
    end
  end

  logic [2:0][31:0]  num_hi;
  logic [2:0][QW-1:0] num_lo;
  logic              dv_vld;
  logic [2:0][QW-1:0] dv_q;
  dv_side_t          dv_side;

  // the fraction shift of the divisor is taken off the dividend
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_hi[i] = s8_pm[i][95:64];
      num_lo[i] = s8_pm[i][63:FRAC_BITS];
    end
  end

  dsf_div #(.QW(QW), .SW($bits(dv_side_t))) u_div (
    .clk(clk), .rst(rst), .ce(ce), .in_vld(s8_vld), .num_hi(num_hi), .num_lo(num_lo),
    .den(s8_len), .side_in(s8_side), .out_vld(dv_vld), .quot(dv_q), .side_out(dv_side)
  );

  // stage 9: exact sums
  logic                    s9_vld, s9_zero;
  logic [2:0][SUM_W-1:0]   s9_fa, s9_fb;
  logic [2:0][SUM_W-1:0]   h_c, dmp_c, g_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_c[i]   = dv_side.zero ? '0 :
                 (dv_side.nh[i] ? -SUM_W'(dv_q[i]) : SUM_W'(dv_q[i]));
      dmp_c[i] = {{(SUM_W-64){dv_side.dmp[i][63]}}, dv_side.dmp[i]};
      g_c[i]   = (i == 1) ? {{(SUM_W-32){cfg.gravity_y[31]}}, cfg.gravity_y} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (ce) begin
      s9_vld <= dv_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s9_fa[i] <= g_c[i] - h_c[i] - dmp_c[i];
        s9_fb[i] <= g_c[i] + h_c[i] + dmp_c[i];
      end
      s9_zero <= dv_side.zero;
    end
  end

  // stage 10: clip into the output register
  logic sat_c;

  always_comb begin
    sat_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sat_c = sat_c | clipped(s9_fa[i]) | clipped(s9_fb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= s9_vld;
    end
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[32*i +: 32]      <= sat32(s9_fa[i]);
        m_tdata[96 + 32*i +: 32] <= sat32(s9_fb[i]);
      end
      m_tuser <= {sat_c, s9_zero};
    end
  end

  `DSF_ASSERT_ALWAYS(a_rst_clears_out, ($past(rst) |-> !m_tvalid), "output valid after reset")

endmodule

@@ sim/tb_top.sv @@
// testbench for damped_spring_force: directed table then random springs,
// forces predicted per transfer and compared in order; depends on dsf_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dsf_pkg::*;

  localparam int FRAC = 16;
  localparam int WDOG_LIMIT = 5000;

  typedef struct {
    logic signed [31:0] fa [3];
    logic signed [31:0] fb [3];
    logic               zero_len;
    logic               sat;
  } force_t;

  typedef struct {
    logic signed [31:0] pa [3];
    logic signed [31:0] pb [3];
    logic signed [31:0] vel [3];
    logic [30:0]        rest;
  } spring_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_tvalid, s_tready;
  logic [319:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [191:0] m_tdata;
  logic [1:0] m_tuser;

  damped_spring_force #(.FRAC_BITS(FRAC)) u_top (.*);

  logic [30:0] k_stiff, k_damp;
  logic signed [31:0] g_y;
  force_t forces_q [$];
  int errors, idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] clip(input logic signed [65:0] v, inout logic flag);
    if (v > 66'sd2147483647) begin
      flag = 1;
      return 32'h7fff_ffff;
    end
    if (v < -66'sd2147483648) begin
      flag = 1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic force_t spring_force(input spring_t s);
    force_t r;
    logic signed [33:0] d [3];
    logic [127:0] rad, rem, trial;
    logic [63:0] len;
    logic signed [65:0] diff, h, dm, g;
    logic [33:0] md;
    logic [191:0] num;
    logic [65:0] dmag;
    rad = 0;
    r.sat = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 34'(s.pa[i]) - 34'(s.pb[i]);
      md = d[i] < 0 ? -d[i] : d[i];
      rad += 128'(md) * 128'(md);
    end
    // bitwise integer square root
    len = 0;
    rem = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 3);
      trial = (128'(len) << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        len = (len << 1) | 1;
      end else begin
        len = len << 1;
      end
    end
    r.zero_len = (len == 0);
    diff = 66'(len) - 66'(s.rest);
    for (int i = 0; i < 3; i++) begin
      h = 0;
      if (!r.zero_len) begin
        md = d[i] < 0 ? -d[i] : d[i];
        num = 192'(k_stiff) * 192'(diff < 0 ? -diff : diff) * 192'(md);
        h = 66'(num / (192'(len) << FRAC));
        if ((diff < 0) != (d[i] < 0)) h = -h;
      end
      dmag = (66'(k_damp) * 66'(s.vel[i] < 0 ? -66'(s.vel[i]) : 66'(s.vel[i]))) >> FRAC;
      dm = s.vel[i] < 0 ? -$signed(dmag) : $signed(dmag);
      g = (i == 1) ? 66'(g_y) : 0;
      r.fa[i] = clip(-h - dm + g, r.sat);
      r.fb[i] = clip(h + dm + g, r.sat);
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_STIFFNESS: k_stiff = val[30:0];
      REG_DAMPING:   k_damp = val[30:0];
      default:       g_y = val;
    endcase
  endtask

  task automatic send_spring(input spring_t s);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    for (int i = 0; i < 3; i++) begin
      s_tdata[32*i +: 32] = s.pa[i];
      s_tdata[96 + 32*i +: 32] = s.pb[i];
      s_tdata[192 + 32*i +: 32] = s.vel[i];
    end
    s_tdata[288 +: 31] = s.rest;
    s_tdata[319] = 0;
    s_tvalid = 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    forces_q = {forces_q, spring_force(s)};
    @(negedge clk);
    s_tvalid = 0;
  endtask

  // wait for the pipeline to drain before touching registers
  task automatic drain();
    while (forces_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2) - 1;
      3: return $signed(16'($urandom)) <<< $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic spring_t rnd_spring();
    spring_t s;
    int mode;
    logic [31:0] w;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      s.pa[i] = mode < 6 ? 32'(signed'(20'($urandom))) : rnd_word();
      s.pb[i] = mode == 9 ? s.pa[i] : (mode < 6 ? 32'(signed'(20'($urandom))) : rnd_word());
      s.vel[i] = mode < 5 ? 32'(signed'(22'($urandom))) : rnd_word();
    end
    w = mode < 6 ? 32'($urandom_range(0, 1 << 20)) : rnd_word();
    s.rest = w[30:0];
    return s;
  endfunction

  // output side: random stall per result, compare against oldest prediction
  initial begin
    force_t want;
    int stall;
    m_tready = 0;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      repeat (stall) @(negedge clk);
      m_tready = 1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      if (forces_q.size() == 0) begin
        report("unexpected result", m_tdata[31:0], 32'h0);
      end else begin
        want = forces_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[32*i +: 32] !== want.fa[i]) report("force_a", m_tdata[32*i +: 32], want.fa[i]);
          if (m_tdata[96 + 32*i +: 32] !== want.fb[i])
            report("force_b", m_tdata[96 + 32*i +: 32], want.fb[i]);
        end
        if (m_tuser[0] !== want.zero_len)
          report("zero_length", 32'(m_tuser[0]), 32'(want.zero_len));
        if (m_tuser[1] !== want.sat) report("saturated", 32'(m_tuser[1]), 32'(want.sat));
      end
      @(negedge clk);
      m_tready = 0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  spring_t dir_tab [14];

  initial begin
    spring_t s;
    force_t r;
    logic [31:0] cfgs [4][3];
    errors = 0;
    idle_cycles = 0;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0;
    k_stiff = 31'(100 << FRAC);
    k_damp = 31'(1 << (FRAC - 1));
    g_y = -642;
    repeat (10) @(negedge clk);
    rst = 0;

    // directed rows: coincident ends, axis-aligned, extremes
    foreach (dir_tab[j]) begin
      for (int i = 0; i < 3; i++) begin
        dir_tab[j].pa[i] = 0; dir_tab[j].pb[i] = 0; dir_tab[j].vel[i] = 0;
      end
      dir_tab[j].rest = 0;
    end
    dir_tab[1].vel[0] = 32'h0001_0000;
    dir_tab[2].pa[0] = 32'h0002_0000; dir_tab[2].rest = 31'h0001_0000;
    dir_tab[3].pa[1] = 32'h0001_0000; dir_tab[3].rest = 31'h0003_0000;
    dir_tab[4].pa[2] = -32'sh0001_0000; dir_tab[4].pb[2] = 32'h0001_0000;
    for (int i = 0; i < 3; i++) begin
      dir_tab[5].pa[i] = 32'h7fff_ffff; dir_tab[5].pb[i] = 32'h8000_0000;
      dir_tab[6].pa[i] = 32'h8000_0000; dir_tab[6].pb[i] = 32'h7fff_ffff;
      dir_tab[7].vel[i] = 32'h7fff_ffff;
      dir_tab[8].vel[i] = 32'h8000_0000;
      dir_tab[9].pa[i] = 32'h7fff_ffff; dir_tab[9].pb[i] = 32'h7fff_ffff;
      dir_tab[10].pa[i] = 32'hffff_ffff;
      dir_tab[11].pb[i] = 32'h0000_0001;
    end
    dir_tab[7].rest = 31'h7fff_ffff;
    dir_tab[10].rest = 31'h7fff_ffff;
    dir_tab[12].pa[0] = 32'h0000_0003; dir_tab[12].pa[1] = 32'h0000_0004;
    dir_tab[13].pa[0] = 32'h0003_0000; dir_tab[13].pa[1] = 32'h0004_0000;
    dir_tab[13].rest = 31'h0005_0000;

    // known results after reset: coincident ends give gravity only
    r = spring_force(dir_tab[0]);
    if (!r.zero_len || r.fa[1] != -642 || r.fb[1] != -642 || r.fa[0] != 0)
      report("reset prediction", r.fa[1], -642);
    foreach (dir_tab[j]) send_spring(dir_tab[j]);
    drain();

    cfgs[0] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    cfgs[1] = '{32'h0, 32'h0, 32'h8000_0000};
    cfgs[2] = '{32'h0001_0000, 32'h0000_0100, 32'h0};
    cfgs[3] = '{32'h0064_0000, 32'h0000_8000, 32'hffff_fd7e};
    for (int p = 0; p < 5; p++) begin
      if (p < 4) begin
        apb_write(REG_STIFFNESS, cfgs[p][0]);
        apb_write(REG_DAMPING, cfgs[p][1]);
        apb_write(REG_GRAVITY_Y, cfgs[p][2]);
      end else begin
        apb_write(REG_STIFFNESS, $urandom);
        apb_write(REG_DAMPING, $urandom);
        apb_write(REG_GRAVITY_Y, $urandom);
      end
      for (int n = 0; n < 108; n++) begin
        s = rnd_spring();
        send_spring(s);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
